### hw/rtl/luhn_pkg.sv
// ----------------------------------------------------------------------------
// Luhn card check package
// Shared widths, constants, codes and helpers for the card number checker.
// ----------------------------------------------------------------------------
package luhn_pkg;

  // Binary input width and decimal digit capacity
  localparam int NUM_BITS   = 54;
  localparam int NUM_DIGITS = 17;
  localparam int BCD_W      = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(NUM_BITS);
  localparam int IDX_W      = 5;

  // Longest number that may carry a brand
  localparam int MAX_DIGITS = 16;

  // Brand length and prefix rules
  localparam int LEN_AMEX     = 15;
  localparam int LEN_VISA_S   = 13;
  localparam int LEN_VISA_L   = 16;
  localparam int LEN_MC       = 16;
  localparam int AMEX_LEAD    = 3;
  localparam int AMEX_NEXT_A  = 4;
  localparam int AMEX_NEXT_B  = 7;
  localparam int VISA_LEAD    = 4;
  localparam int MC_LEAD      = 5;
  localparam int MC_NEXT_LO   = 1;
  localparam int MC_NEXT_HI   = 5;
  localparam int RADIX        = 10;

  typedef enum logic [1:0] {
    BRAND_NONE = 2'd0,
    BRAND_AMEX = 2'd1,
    BRAND_VISA = 2'd2,
    BRAND_MC   = 2'd3
  } brand_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Control strobes from the sequencer to the datapath
  typedef struct packed {
    logic load;   // take a new number, clear accumulators
    logic conv;   // one binary to decimal step
    logic shift;  // move one decimal digit out, least significant first
  } luhn_ctl_t;

  // Double a decimal digit and sum the digits of the product
  function automatic logic [3:0] dbl_digit(input logic [3:0] d);
    logic [4:0] t;
    t = {d, 1'b0};
    if (t >= 5'(RADIX)) begin
      dbl_digit = 4'(t - 5'(RADIX - 1));
    end else begin
      dbl_digit = t[3:0];
    end
  endfunction

endpackage

### hw/rtl/luhn_bcd_conv.sv
// ----------------------------------------------------------------------------
// Luhn bit-serial decimal converter
// Shift-and-add-3 conversion, one binary bit per cycle, then shifts the
// decimal digits out one per cycle, least significant first.
// ----------------------------------------------------------------------------
module luhn_bcd_conv (
  input  logic                         clk,
  input  luhn_pkg::luhn_ctl_t          ctl,
  input  logic [luhn_pkg::NUM_BITS-1:0] number,
  output logic [3:0]                   digit
);

  logic [luhn_pkg::NUM_BITS-1:0] bin_r;
  logic [luhn_pkg::NUM_BITS-1:0] bin_nxt;
  logic [luhn_pkg::BCD_W-1:0]    bcd_r;
  logic [luhn_pkg::BCD_W-1:0]    bcd_nxt;
  logic [luhn_pkg::BCD_W-1:0]    bcd_adj;

  // Correct every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < luhn_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // Load, convert or shift out
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    if (ctl.load) begin
      bin_nxt = number;
      bcd_nxt = '0;
    end else if (ctl.conv) begin
      bin_nxt = {bin_r[luhn_pkg::NUM_BITS-2:0], 1'b0};
      bcd_nxt = {bcd_adj[luhn_pkg::BCD_W-2:0], bin_r[luhn_pkg::NUM_BITS-1]};
    end else if (ctl.shift) begin
      bcd_nxt = {4'd0, bcd_r[luhn_pkg::BCD_W-1:4]};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digit = bcd_r[3:0];

endmodule

### hw/rtl/luhn_digit_scan.sv
// ----------------------------------------------------------------------------
// Luhn digit scanner
// Takes one decimal digit per cycle, least significant first, and keeps the
// running mod-10 sum, the digit count and the two leading digits.
// ----------------------------------------------------------------------------
module luhn_digit_scan (
  input  logic                      clk,
  input  luhn_pkg::luhn_ctl_t       ctl,
  input  logic [3:0]                digit,
  output logic                      checksum_ok,
  output luhn_pkg::brand_t          brand,
  output logic [luhn_pkg::IDX_W-1:0] digit_count
);

  logic [luhn_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [luhn_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]                 sum_r, sum_nxt;
  logic [3:0]                 prev_r, prev_nxt;
  logic [3:0]                 lead1_r, lead1_nxt;
  logic [3:0]                 lead2_r, lead2_nxt;
  logic [3:0]                 term;
  logic [4:0]                 sum_wide;

  // Double every second digit from the right
  always_comb begin
    term     = idx_r[0] ? luhn_pkg::dbl_digit(digit) : digit;
    sum_wide = {1'b0, sum_r} + {1'b0, term};
  end

  // Accumulate one digit
  always_comb begin
    idx_nxt   = idx_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    lead1_nxt = lead1_r;
    lead2_nxt = lead2_r;
    if (ctl.load) begin
      idx_nxt   = '0;
      cnt_nxt   = '0;
      sum_nxt   = '0;
      prev_nxt  = '0;
      lead1_nxt = '0;
      lead2_nxt = '0;
    end else if (ctl.shift) begin
      idx_nxt  = idx_r + 1'b1;
      prev_nxt = digit;
      if (sum_wide >= 5'(luhn_pkg::RADIX)) begin
        sum_nxt = 4'(sum_wide - 5'(luhn_pkg::RADIX));
      end else begin
        sum_nxt = sum_wide[3:0];
      end
      // A nonzero digit is the leading one so far
      if (digit != 4'd0) begin
        cnt_nxt   = idx_r + 1'b1;
        lead1_nxt = digit;
        lead2_nxt = prev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    cnt_r   <= cnt_nxt;
    sum_r   <= sum_nxt;
    prev_r  <= prev_nxt;
    lead1_r <= lead1_nxt;
    lead2_r <= lead2_nxt;
  end

  // Classify the brand of a passing number from length and prefix
  always_comb begin
    brand = luhn_pkg::BRAND_NONE;
    if (checksum_ok && cnt_r >= 5'd2 &&
        cnt_r <= luhn_pkg::IDX_W'(luhn_pkg::MAX_DIGITS)) begin
      priority if (cnt_r == luhn_pkg::IDX_W'(luhn_pkg::LEN_AMEX) &&
                   lead1_r == 4'(luhn_pkg::AMEX_LEAD) &&
                   (lead2_r == 4'(luhn_pkg::AMEX_NEXT_A) ||
                    lead2_r == 4'(luhn_pkg::AMEX_NEXT_B))) begin
        brand = luhn_pkg::BRAND_AMEX;
      end else if ((cnt_r == luhn_pkg::IDX_W'(luhn_pkg::LEN_VISA_S) ||
                    cnt_r == luhn_pkg::IDX_W'(luhn_pkg::LEN_VISA_L)) &&
                   lead1_r == 4'(luhn_pkg::VISA_LEAD)) begin
        brand = luhn_pkg::BRAND_VISA;
      end else if (cnt_r == luhn_pkg::IDX_W'(luhn_pkg::LEN_MC) &&
                   lead1_r == 4'(luhn_pkg::MC_LEAD) &&
                   lead2_r >= 4'(luhn_pkg::MC_NEXT_LO) &&
                   lead2_r <= 4'(luhn_pkg::MC_NEXT_HI)) begin
        brand = luhn_pkg::BRAND_MC;
      end else begin
        brand = luhn_pkg::BRAND_NONE;
      end
    end
  end

  assign checksum_ok = (cnt_r != '0) && (sum_r == 4'd0);
  assign digit_count = cnt_r;

endmodule

### hw/rtl/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// Luhn card number checker
// Converts a binary card number to decimal bit-serially, runs the Luhn
// mod-10 check digit by digit, counts digits and classifies the brand.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_card_number carries one binary
//   card number per transfer. Output channel out_valid / out_stall carries
//   out_checksum_ok, out_brand and out_digit_count, one result per input.
//   One number is in work at a time: in_stall stays high from the transfer
//   until the result has moved into the output register.
//   Steps: shift-and-add-3 conversion (one input bit each step), then the
//   digit scan (one decimal digit each step), then the load of the output
//   register, which raises out_valid. The next number is taken only when
//   the sequencer is back in idle, after the output register load.
//   While a result waits in the output register the next number is taken
//   and worked; it holds in the final step until the register is free.
//   Reset (rst_n low, synchronous) returns to idle and clears out_valid.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [luhn_pkg::NUM_BITS-1:0] in_card_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_checksum_ok,
  output logic [1:0]                    out_brand,
  output logic [luhn_pkg::IDX_W-1:0]    out_digit_count
);

  localparam logic [luhn_pkg::BIT_CNT_W-1:0] LAST_BIT =
    luhn_pkg::BIT_CNT_W'(luhn_pkg::NUM_BITS - 1);
  localparam logic [luhn_pkg::BIT_CNT_W-1:0] LAST_DIGIT =
    luhn_pkg::BIT_CNT_W'(luhn_pkg::NUM_DIGITS - 1);

  luhn_pkg::state_t               state_r, state_nxt;
  logic [luhn_pkg::BIT_CNT_W-1:0] step_r, step_nxt;
  luhn_pkg::luhn_ctl_t            ctl;
  logic                           out_valid_r, out_valid_nxt;
  logic                           ok_r;
  luhn_pkg::brand_t               brand_r;
  logic [luhn_pkg::IDX_W-1:0]     count_r;
  logic                           in_xfer;
  logic                           out_load;
  logic [3:0]                     digit;
  logic                           scan_ok;
  luhn_pkg::brand_t               scan_brand;
  logic [luhn_pkg::IDX_W-1:0]     scan_count;

  luhn_bcd_conv u_conv (
    .clk    (clk),
    .ctl    (ctl),
    .number (in_card_number),
    .digit  (digit)
  );

  luhn_digit_scan u_scan (
    .clk         (clk),
    .ctl         (ctl),
    .digit       (digit),
    .checksum_ok (scan_ok),
    .brand       (scan_brand),
    .digit_count (scan_count)
  );

  assign in_stall = (state_r != luhn_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Sequence conversion, scan and output load
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctl       = '0;
    out_load  = 1'b0;
    unique case (state_r)
      luhn_pkg::ST_IDLE: begin
        if (in_xfer) begin
          ctl.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = luhn_pkg::ST_CONV;
        end
      end
      luhn_pkg::ST_CONV: begin
        ctl.conv = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_BIT) begin
          step_nxt  = '0;
          state_nxt = luhn_pkg::ST_SCAN;
        end
      end
      luhn_pkg::ST_SCAN: begin
        ctl.shift = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == LAST_DIGIT) begin
          state_nxt = luhn_pkg::ST_DONE;
        end
      end
      luhn_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = luhn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = luhn_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: fill on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= luhn_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      ok_r    <= scan_ok;
      brand_r <= scan_brand;
      count_r <= scan_count;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_checksum_ok = ok_r;
  assign out_brand       = brand_r;
  assign out_digit_count = count_r;

`ifndef ASSERT_OFF
  a_start_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == luhn_pkg::ST_CONV && step_r == '0)
    else $error("conversion did not start after input transfer");

  a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_brand != luhn_pkg::BRAND_NONE |-> out_checksum_ok)
    else $error("brand reported without a passing check");

  a_ok_needs_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_checksum_ok |-> out_digit_count != '0)
    else $error("check passed on a zero number");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_count <= luhn_pkg::IDX_W'(luhn_pkg::NUM_DIGITS))
    else $error("digit count out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r || !out_stall)
    else $error("output register overwritten while stalled");
`endif

endmodule
